[hw/rtl/sorted_set_insert_remove_defines.svh]
// Assertion macros for the sorted set block.
// The asserting scope must provide clk and rst_n.
`ifndef SORTED_SET_INSERT_REMOVE_DEFINES_SVH
`define SORTED_SET_INSERT_REMOVE_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define SSIR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted set check failed");

// Next-cycle implication, disabled in reset
`define SSIR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted set check failed");

`endif

[hw/rtl/ssir_pkg.sv]
package ssir_pkg;

    localparam int SSIR_CAPACITY = 16;
    localparam int VALUE_W       = 32;
    localparam int RANK_W        = 4;
    localparam int COUNT_OUT_W   = 5;
    localparam int PADDR_W       = 3;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FIND   = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    localparam logic REG_ORDER = 1'b0;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Broadcast to every cell of the chain
    typedef struct packed {
        logic                      ins_en;
        logic                      rem_en;
        logic signed [VALUE_W-1:0] key;
    } cell_ctrl_t;

endpackage

[hw/rtl/ssir_in_if.sv]
interface ssir_in_if
    import ssir_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [1:0]                operation;
    logic signed [VALUE_W-1:0] value;
    logic [RANK_W-1:0]         rank;

    modport source (output valid, operation, value, rank, input ready);
    modport sink   (input valid, operation, value, rank, output ready);
endinterface

[hw/rtl/ssir_out_if.sv]
interface ssir_out_if
    import ssir_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] read_value;
    logic [COUNT_OUT_W-1:0]    entry_count;

    modport source (output valid, status, read_value, entry_count, input ready);
    modport sink   (input valid, status, read_value, entry_count, output ready);
endinterface

[hw/rtl/ssir_cell.sv]
module ssir_cell
    import ssir_pkg::*;
(
    input  logic                      clk,
    input  cell_ctrl_t                ctrl,
    input  logic                      valid,
    input  logic                      lt_left,
    input  logic signed [VALUE_W-1:0] left_value,
    input  logic signed [VALUE_W-1:0] right_value,
    output logic signed [VALUE_W-1:0] value,
    output logic                      lt,
    output logic                      eq
);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;

    // Compare the held entry against the broadcast key
    assign lt    = valid && (value_reg < ctrl.key);
    assign eq    = valid && (value_reg == ctrl.key);
    assign value = value_reg;

    // Keep entries below the key, open a gap or close one above it
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.ins_en && !lt)
        begin
            value_next = lt_left ? ctrl.key : left_value;
        end
        else if (ctrl.rem_en && !lt)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

[hw/rtl/sorted_set_insert_remove.sv]
// A result is registered in the execute state that follows the acceptance of its item.
// Items are taken one at a time, none while one executes; the compare-and-shift step of the
// cell chain, where every cell sees the key at once, runs in that execute state.
// Reset clears the entry count, the order register and the handshake state;
// cell contents stay undefined and are never read before written.
module sorted_set_insert_remove
    import ssir_pkg::*;
#(
    parameter int CAPACITY = SSIR_CAPACITY
)
(
    input  logic                clk,
    input  logic                rst_n,
    ssir_in_if.sink             in_ch,
    ssir_out_if.source          out_ch,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      order_reg;
    op_t                       op_reg;
    logic signed [VALUE_W-1:0] key_reg;
    logic [IDX_W-1:0]          sel_reg;
    logic                      rank_ok_reg;

    logic                      out_valid_reg, out_valid_next;
    logic [1:0]                status_reg, status_next;
    logic signed [VALUE_W-1:0] read_value_reg, read_value_next;
    logic [COUNT_OUT_W-1:0]    entry_count_reg;

    logic                      accept;
    logic                      present;
    logic [CMP_W-1:0]          rank_ext, cnt_ext, pos_ext;
    logic                      ins_en;
    logic                      rem_en;
    cell_ctrl_t                ctrl;

    logic signed [VALUE_W-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]       cell_lt;
    logic [CAPACITY-1:0]       cell_eq;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1] == REG_ORDER) ? {31'b0, order_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && (paddr[PADDR_W-1] == REG_ORDER))
        begin
            order_reg <= pwdata[0];
        end
    end

    // Cell chain
    assign ctrl = '{ins_en: ins_en, rem_en: rem_en, key: key_reg};

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                      lt_left_w;
        logic signed [VALUE_W-1:0] left_w;
        logic signed [VALUE_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign lt_left_w = 1'b1;
            assign left_w    = key_reg;
        end
        else
        begin : g_mid
            assign lt_left_w = cell_lt[i-1];
            assign left_w    = cell_value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = cell_value[i];
        end
        else
        begin : g_inner
            assign right_w = cell_value[i+1];
        end

        ssir_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .valid       (CNT_W'(i) < count_reg),
            .lt_left     (lt_left_w),
            .left_value  (left_w),
            .right_value (right_w),
            .value       (cell_value[i]),
            .lt          (cell_lt[i]),
            .eq          (cell_eq[i])
        );
    end

    assign present = |cell_eq;

    // Map rank to slot; storage is always ascending
    assign accept   = in_ch.valid && in_ch.ready;
    assign rank_ext = CMP_W'(in_ch.rank);
    assign cnt_ext  = CMP_W'(count_reg);
    assign pos_ext  = order_reg ? (cnt_ext - CMP_W'(1) - rank_ext) : rank_ext;

    // Control and result formation
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        status_next     = status_reg;
        read_value_next = read_value_reg;
        ins_en          = 1'b0;
        rem_en          = 1'b0;
        in_ch.ready     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = !out_valid_reg || out_ch.ready;
                if (in_ch.valid && in_ch.ready)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next      = ST_IDLE;
                out_valid_next  = 1'b1;
                status_next     = STATUS_OK;
                read_value_next = '0;
                unique case (op_reg)
                    OP_INSERT:
                    begin
                        if (present)
                        begin
                            status_next = STATUS_MISS;
                        end
                        else if (count_reg == CNT_W'(CAPACITY))
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            ins_en     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (present)
                        begin
                            rem_en     = 1'b1;
                            count_next = count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            status_next = STATUS_MISS;
                        end
                    end
                    OP_FIND:
                    begin
                        status_next = present ? STATUS_OK : STATUS_MISS;
                    end
                    OP_READ:
                    begin
                        if (rank_ok_reg)
                        begin
                            read_value_next = cell_value[sel_reg];
                        end
                        else
                        begin
                            status_next = STATUS_MISS;
                        end
                    end
                    default:
                    begin
                        status_next = STATUS_MISS;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the item and the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= op_t'(in_ch.operation);
            key_reg     <= in_ch.value;
            sel_reg     <= pos_ext[IDX_W-1:0];
            rank_ok_reg <= rank_ext < cnt_ext;
        end
        if (state_reg == ST_EXEC)
        begin
            status_reg      <= status_next;
            read_value_reg  <= read_value_next;
            entry_count_reg <= COUNT_OUT_W'(count_next);
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.status      = status_reg;
    assign out_ch.read_value  = read_value_reg;
    assign out_ch.entry_count = entry_count_reg;

endmodule

[hw/rtl/ssir_checker.sv]
`include "sorted_set_insert_remove_defines.svh"

module ssir_checker
    import ssir_pkg::*;
#(
    parameter int CAPACITY = SSIR_CAPACITY
)
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic [1:0]                status,
    input logic signed [VALUE_W-1:0] read_value,
    input logic [COUNT_OUT_W-1:0]    entry_count
);

    // One item at a time
    `SSIR_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

    // Every accepted item yields a result once the execute state has registered it
    `SSIR_ASSERT_NEXT(a_result_follows, in_valid && in_ready, ##1 out_valid)

    // A full report comes only with the count at capacity
    `SSIR_ASSERT_NOW(a_full_at_cap, out_valid && (status == STATUS_FULL),
        entry_count == COUNT_OUT_W'(CAPACITY))

    // A read value is shown only with a success status
    `SSIR_ASSERT_NOW(a_value_on_ok, out_valid && (status != STATUS_OK), read_value == '0)

endmodule

bind sorted_set_insert_remove ssir_checker #(.CAPACITY(CAPACITY)) u_ssir_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .status      (out_ch.status),
    .read_value  (out_ch.read_value),
    .entry_count (out_ch.entry_count)
);
